// ===== hw/rtl/delta_list_task_scheduler_defines.svh =====
// ----------------------------------------------------------------------------
// Delta list task scheduler: assertion macros
// Shared check macros, clocked on clk and disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef DELTA_LIST_TASK_SCHEDULER_DEFINES_SVH
`define DELTA_LIST_TASK_SCHEDULER_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define DLTS_CHECK_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define DLTS_CHECK_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/dlts_pkg.sv =====
// ----------------------------------------------------------------------------
// Delta list task scheduler: package
// Sizes, field codes, table entry and cell command types.
// ----------------------------------------------------------------------------
`default_nettype none

package dlts_pkg;

  // table size and derived widths
  localparam int MAX_TASKS = 16;
  localparam int IDX_W     = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CNT_W     = $clog2(MAX_TASKS + 1);

  // field widths
  localparam int MODE_W     = 2;
  localparam int MS_W       = 16;
  localparam int DELTA_W    = 13;
  localparam int PERIOD_W   = 16;
  localparam int TAG_W      = 8;
  localparam int STATUS_W   = 2;
  localparam int PEND_W     = 8;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 8;

  // ms to ticks: x / 10 == (x * 52429) >> 19 for any 16-bit x
  localparam int              PROD_W      = 32;
  localparam logic [MS_W-1:0] DIV10_MUL   = 16'd52429;
  localparam int              DIV10_SHIFT = 19;

  localparam logic [PEND_W-1:0] PEND_MAX = 8'd255;

  // operation codes (tuser of the input beat)
  localparam logic [MODE_W-1:0] MODE_TICK     = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ADD      = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DISPATCH = 2'd2;

  // result codes (tuser of the output beat)
  localparam logic [STATUS_W-1:0] STATUS_NONE  = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_RUN   = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_ADDED = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd3;

  typedef struct packed {
    logic [DELTA_W-1:0]  delta;
    logic [PERIOD_W-1:0] period;
    logic [TAG_W-1:0]    label;
  } entry_t;

  typedef enum logic [1:0] {
    CMD_HOLD,
    CMD_DEC,
    CMD_POP,
    CMD_INSERT
  } cmd_op_t;

  // broadcast to every cell of the chain
  typedef struct packed {
    cmd_op_t          op;
    logic [IDX_W-1:0] pos;
    entry_t           fresh;
  } cell_cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DIVIDE,
    ST_SEARCH,
    ST_FINISH
  } state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/dlts_cell.sv =====
// ----------------------------------------------------------------------------
// Delta list task scheduler: table cell
// One delta list slot; decrements as head, loads from its left or right
// neighbor on an insert or head removal, fixes successor delta on insert.
// ----------------------------------------------------------------------------
`default_nettype none

module dlts_cell (
  input  logic                      clk,
  input  logic [dlts_pkg::IDX_W-1:0] cell_idx,
  input  dlts_pkg::cell_cmd_t       cmd,
  input  dlts_pkg::entry_t          from_left,
  input  dlts_pkg::entry_t          from_right,
  output dlts_pkg::entry_t          entry
);
  import dlts_pkg::*;

  entry_t         entry_next;
  logic [IDX_W:0] idx_ext;
  logic [IDX_W:0] succ_ext;

  assign idx_ext  = {1'b0, cell_idx};
  assign succ_ext = {1'b0, cmd.pos} + (IDX_W + 1)'(1);

  // slot update
  always_comb begin
    entry_next = entry;
    case (cmd.op)
      CMD_DEC: begin
        if (cell_idx == '0) begin
          entry_next.delta = entry.delta - DELTA_W'(1);
        end
      end
      CMD_POP: begin
        entry_next = from_right;
      end
      CMD_INSERT: begin
        if (cell_idx == cmd.pos) begin
          entry_next = cmd.fresh;
        end else if (idx_ext == succ_ext) begin
          // old occupant of the insert slot: delta now relative to new entry
          entry_next       = from_left;
          entry_next.delta = from_left.delta - cmd.fresh.delta;
        end else if (cell_idx > cmd.pos) begin
          entry_next = from_left;
        end
      end
      default: begin
        entry_next = entry;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/delta_list_task_scheduler.sv =====
// ----------------------------------------------------------------------------
// Delta list task scheduler
// Timed task table kept as a chain of cells ordered by due time.
// ----------------------------------------------------------------------------
// Usage:
//   Input beat (s_*): tuser selects tick, add or dispatch poll; tdata carries
//   the delay, period and tag of an added task. One output beat (m_*) per
//   input beat: tuser is the status, tdata the tag of a dispatched task.
//   Path of a beat: taken in the idle state, then run in the exec state. A
//   tick, an unused mode, a poll that runs nothing or runs a one-shot task,
//   or an add into a full table then goes to the finish state. An add, or a
//   dispatch of a periodic task, first turns the delay into ticks in the
//   divide state; the insert search then compares one cell per cycle and
//   moves past each entry the new entry walks past. The finish state loads
//   the output register; the next input beat is taken only after that.
//   A result waits in the output register while m_tready is low; a new
//   item is accepted meanwhile, and its own result waits until the
//   register is free. Reset empties the table and clears the pending run
//   count; the cells themselves are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none
`include "delta_list_task_scheduler_defines.svh"

module delta_list_task_scheduler (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [dlts_pkg::IN_DATA_W-1:0]   s_tdata,  // delay_ms, period_ms, task_tag
  input  logic [dlts_pkg::MODE_W-1:0]      s_tuser,  // mode
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [dlts_pkg::OUT_DATA_W-1:0]  m_tdata,  // run_tag
  output logic [dlts_pkg::STATUS_W-1:0]    m_tuser   // status
);
  import dlts_pkg::*;

  // control registers
  state_t              state, state_next;
  logic [CNT_W-1:0]    count, count_next;
  logic [PEND_W-1:0]   pending, pending_next;
  logic                m_tvalid_next;

  // payload registers
  logic [MODE_W-1:0]   mode, mode_next;
  logic [MS_W-1:0]     delay_ms, delay_ms_next;
  logic [PERIOD_W-1:0] period_ms, period_ms_next;
  logic [TAG_W-1:0]    tag, tag_next;
  logic [DELTA_W-1:0]  d, d_next;
  logic [IDX_W-1:0]    pos, pos_next;
  logic [STATUS_W-1:0] res_status, res_status_next;
  logic [TAG_W-1:0]    res_tag, res_tag_next;
  logic [OUT_DATA_W-1:0] m_tdata_next;
  logic [STATUS_W-1:0]   m_tuser_next;

  // chain
  cell_cmd_t cmd;
  entry_t    cells [MAX_TASKS];
  entry_t    head;
  entry_t    sel;

  // decode
  logic              exec_run;
  logic              search_go;
  logic              out_free;
  logic              table_full;
  logic [PROD_W-1:0] product;

  assign s_tready   = (state == ST_IDLE);
  assign head       = cells[0];
  assign sel        = cells[pos];
  assign out_free   = !m_tvalid || m_tready;
  assign table_full = (count == CNT_W'(MAX_TASKS));
  assign exec_run   = (mode == MODE_DISPATCH) && (count != '0) && (pending != '0);
  assign search_go  = (CNT_W'(pos) < count) && (d >= sel.delta);
  assign product    = PROD_W'(delay_ms) * PROD_W'(DIV10_MUL);

  // row of cells
  for (genvar g = 0; g < MAX_TASKS; g++) begin : g_cell
    entry_t left_in;
    entry_t right_in;
    if (g == 0) begin : g_first
      assign left_in = '0;
    end else begin : g_inner_l
      assign left_in = cells[g-1];
    end
    if (g == MAX_TASKS - 1) begin : g_last
      assign right_in = '0;
    end else begin : g_inner_r
      assign right_in = cells[g+1];
    end
    dlts_cell u_cell (
      .clk       (clk),
      .cell_idx  (IDX_W'(g)),
      .cmd       (cmd),
      .from_left (left_in),
      .from_right(right_in),
      .entry     (cells[g])
    );
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        if (mode == MODE_ADD) begin
          state_next = table_full ? ST_FINISH : ST_DIVIDE;
        end else if (exec_run && (head.period != '0)) begin
          state_next = ST_DIVIDE;
        end else begin
          state_next = ST_FINISH;
        end
      end
      ST_DIVIDE: begin
        state_next = ST_SEARCH;
      end
      ST_SEARCH: begin
        if (!search_go) state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // datapath and outputs
  always_comb begin
    count_next      = count;
    pending_next    = pending;
    mode_next       = mode;
    delay_ms_next   = delay_ms;
    period_ms_next  = period_ms;
    tag_next        = tag;
    d_next          = d;
    pos_next        = pos;
    res_status_next = res_status;
    res_tag_next    = res_tag;
    m_tvalid_next   = m_tvalid && !m_tready;
    m_tdata_next    = m_tdata;
    m_tuser_next    = m_tuser;
    cmd.op          = CMD_HOLD;
    cmd.pos         = pos;
    cmd.fresh.delta  = d;
    cmd.fresh.period = period_ms;
    cmd.fresh.label  = tag;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          mode_next      = s_tuser;
          delay_ms_next  = s_tdata[MS_W-1:0];
          period_ms_next = s_tdata[MS_W +: PERIOD_W];
          tag_next       = s_tdata[MS_W+PERIOD_W +: TAG_W];
        end
      end
      ST_EXEC: begin
        res_status_next = STATUS_NONE;
        res_tag_next    = '0;
        case (mode)
          MODE_TICK: begin
            // count down the head, then count runs once it is due
            if (count != '0) begin
              if (head.delta == '0) begin
                if (pending != PEND_MAX) pending_next = pending + PEND_W'(1);
              end else begin
                cmd.op = CMD_DEC;
              end
            end
          end
          MODE_ADD: begin
            res_status_next = table_full ? STATUS_FULL : STATUS_ADDED;
          end
          MODE_DISPATCH: begin
            // run the head, drop it, and queue the repeat if periodic
            if (exec_run) begin
              res_status_next = STATUS_RUN;
              res_tag_next    = head.label;
              pending_next    = '0;
              cmd.op          = CMD_POP;
              count_next      = count - CNT_W'(1);
              delay_ms_next   = head.period;
              period_ms_next  = head.period;
              tag_next        = head.label;
            end
          end
          default: begin
            res_status_next = STATUS_NONE;
          end
        endcase
      end
      ST_DIVIDE: begin
        d_next   = product[DIV10_SHIFT +: DELTA_W];
        pos_next = '0;
      end
      ST_SEARCH: begin
        // walk one cell a beat; insert where the remaining delay stops
        if (search_go) begin
          d_next   = d - sel.delta;
          pos_next = pos + IDX_W'(1);
        end else begin
          cmd.op     = CMD_INSERT;
          count_next = count + CNT_W'(1);
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          m_tvalid_next = 1'b1;
          m_tuser_next  = res_status;
          m_tdata_next  = res_tag;
        end
      end
      default: begin
        cmd.op = CMD_HOLD;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      count    <= '0;
      pending  <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      pending  <= pending_next;
      m_tvalid <= m_tvalid_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    mode       <= mode_next;
    delay_ms   <= delay_ms_next;
    period_ms  <= period_ms_next;
    tag        <= tag_next;
    d          <= d_next;
    pos        <= pos_next;
    res_status <= res_status_next;
    res_tag    <= res_tag_next;
    m_tdata    <= m_tdata_next;
    m_tuser    <= m_tuser_next;
  end

  // checks
  `DLTS_CHECK_NOW(a_insert_room, (state == ST_SEARCH) && !search_go, count < CNT_W'(MAX_TASKS), "insert into a full table")
  `DLTS_CHECK_NOW(a_search_bound, state == ST_SEARCH, CNT_W'(pos) <= count, "search ran past the last entry")
  `DLTS_CHECK_NEXT(a_run_clears, (state == ST_EXEC) && exec_run, pending == '0, "pending runs kept after dispatch")
  `DLTS_CHECK_NEXT(a_accept_exec, s_tvalid && s_tready, state == ST_EXEC, "accepted beat not executed")

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Delta list task scheduler: self-checking testbench
// Drives tick, add and dispatch-poll beats into the scheduler and checks each
// result beat against a cycle-free software copy of the timer table. A short
// table of directed beats comes first, then random phases: mixed traffic,
// table fills, raw noise and long tick floods that push the pending-run count
// to its ceiling. Both stream sides idle and stall at random.
// ----------------------------------------------------------------------------

module tb_top;
  import dlts_pkg::*;

  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int                FEED_ITEMS  = 2000;
  localparam int                DRAIN_WAIT  = 30;

  typedef struct packed {
    logic [MODE_W-1:0]   mode;
    logic [MS_W-1:0]     delay_ms;
    logic [PERIOD_W-1:0] period_ms;
    logic [TAG_W-1:0]    tag;
  } sched_in_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [TAG_W-1:0]    run_tag;
  } sched_out_t;

  typedef struct packed {
    sched_in_t  stim;
    logic       pinned;      // result typed in by hand
    sched_out_t pinned_res;
  } dir_row_t;

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;   // delay_ms, period_ms, task_tag
  logic [MODE_W-1:0]     s_tuser;   // mode
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;   // run_tag
  logic [STATUS_W-1:0]   m_tuser;   // status

  delta_list_task_scheduler uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // shadow copy of the timer table
  logic [DELTA_W-1:0]  tbl_delta  [MAX_TASKS];
  logic [PERIOD_W-1:0] tbl_period [MAX_TASKS];
  logic [TAG_W-1:0]    tbl_tag    [MAX_TASKS];
  int                  tbl_used  = 0;
  logic [PEND_W-1:0]   head_runs = '0;

  sched_out_t sched_q [$];   // expected result beats, oldest first
  sched_out_t head_exp;
  dir_row_t   dir_rows [$];

  int items_fed   = 0;
  int burst_left  = 0;
  int mismatches  = 0;
  int beats_seen  = 0;
  int n_tick      = 0;
  int n_add       = 0;
  int n_full      = 0;
  int n_poll      = 0;
  int n_run       = 0;
  int n_sat       = 0;
  int n_flood     = 0;
  int rx_left     = 0;
  int rx_style    = 0;

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // hard stop
  initial begin
    #(20_000_000);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // ordered insert: equal due times go behind the entries already queued
  function automatic bit table_insert(logic [MS_W-1:0] delay_ms, logic [PERIOD_W-1:0] period_ms,
                                      logic [TAG_W-1:0] tag);
    logic [MS_W-1:0] ticks;
    int              pos;
    ticks = delay_ms / 16'd10;
    pos   = 0;
    if (tbl_used >= MAX_TASKS) return 1'b0;
    while (pos < tbl_used && ticks >= MS_W'(tbl_delta[pos])) begin
      ticks = ticks - MS_W'(tbl_delta[pos]);
      pos++;
    end
    for (int k = tbl_used; k > pos; k--) begin
      tbl_delta[k]  = tbl_delta[k-1];
      tbl_period[k] = tbl_period[k-1];
      tbl_tag[k]    = tbl_tag[k-1];
    end
    tbl_delta[pos]  = ticks[DELTA_W-1:0];
    tbl_period[pos] = period_ms;
    tbl_tag[pos]    = tag;
    tbl_used++;
    if (pos + 1 < tbl_used) tbl_delta[pos+1] = tbl_delta[pos+1] - ticks[DELTA_W-1:0];
    return 1'b1;
  endfunction

  // next result beat for one accepted input beat; updates the shadow table
  function automatic sched_out_t predict_schedule(sched_in_t it);
    sched_out_t          r;
    logic [PERIOD_W-1:0] per;
    logic [TAG_W-1:0]    lbl;
    r = '0;
    case (it.mode)
      MODE_TICK: begin
        n_tick++;
        if (tbl_used != 0) begin
          if (tbl_delta[0] != '0) tbl_delta[0] = tbl_delta[0] - 1'b1;
          else if (head_runs != PEND_MAX) head_runs = head_runs + 1'b1;
          else n_sat++;
        end
      end
      MODE_ADD: begin
        n_add++;
        if (table_insert(it.delay_ms, it.period_ms, it.tag)) begin
          r.status = STATUS_ADDED;
        end else begin
          r.status = STATUS_FULL;
          n_full++;
        end
      end
      MODE_DISPATCH: begin
        n_poll++;
        if (tbl_used != 0 && head_runs != '0) begin
          per       = tbl_period[0];
          lbl       = tbl_tag[0];
          r.status  = STATUS_RUN;
          r.run_tag = lbl;
          head_runs = '0;
          for (int k = 1; k < tbl_used; k++) begin
            tbl_delta[k-1]  = tbl_delta[k];
            tbl_period[k-1] = tbl_period[k];
            tbl_tag[k-1]    = tbl_tag[k];
          end
          tbl_used--;
          // periodic task goes back in; the slot just freed is always there
          if (per != '0) void'(table_insert(per, per, lbl));
          n_run++;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic dir_row_t mk_row(logic [MODE_W-1:0] mode, logic [MS_W-1:0] delay_ms,
                                      logic [PERIOD_W-1:0] period_ms, logic [TAG_W-1:0] tag,
                                      logic pinned, logic [STATUS_W-1:0] status,
                                      logic [TAG_W-1:0] run_tag);
    dir_row_t r;
    r.stim.mode               = mode;
    r.stim.delay_ms           = delay_ms;
    r.stim.period_ms          = period_ms;
    r.stim.tag                = tag;
    r.pinned                  = pinned;
    r.pinned_res.status       = status;
    r.pinned_res.run_tag      = run_tag;
    return r;
  endfunction

  function automatic sched_in_t rand_add();
    sched_in_t it;
    int        w;
    it.mode = MODE_ADD;
    it.tag  = TAG_W'($urandom);
    w       = $urandom_range(0, 99);
    if (w < 70)      it.delay_ms = MS_W'($urandom_range(0, 300));
    else if (w < 80) it.delay_ms = '0;
    else if (w < 88) it.delay_ms = 16'hFFFF - MS_W'($urandom_range(0, 15));
    else             it.delay_ms = MS_W'($urandom);
    w = $urandom_range(0, 99);
    if (w < 50)      it.period_ms = '0;
    else if (w < 85) it.period_ms = PERIOD_W'($urandom_range(10, 400));
    else             it.period_ms = PERIOD_W'($urandom);
    return it;
  endfunction

  function automatic sched_in_t rand_mixed();
    sched_in_t it;
    int        w;
    it = sched_in_t'({$urandom, $urandom});
    w  = $urandom_range(0, 99);
    if (w < 45)      it.mode = MODE_TICK;
    else if (w < 65) it = rand_add();
    else if (w < 95) it.mode = MODE_DISPATCH;
    else             it.mode = MODE_UNUSED;
    return it;
  endfunction

  // sender: bursts of beats separated by random gaps
  task automatic pace_sender();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80) : $urandom_range(0, 10);
    end
  endtask

  task automatic send_item(input sched_in_t it, input logic pinned, input sched_out_t pinned_res);
    sched_out_t want;
    s_tvalid <= 1'b1;
    s_tuser  <= it.mode;
    s_tdata  <= {it.tag, it.period_ms, it.delay_ms};
    do @(posedge clk); while (!s_tready);
    want = predict_schedule(it);
    sched_q.push_back(pinned ? pinned_res : want);
    if (it.mode != MODE_UNUSED) items_fed++;
    pace_sender();
  endtask

  // hold the sender until every outstanding result has come back
  task automatic wait_drain();
    if (s_tvalid) s_tvalid <= 1'b0;
    while (sched_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // long run of ticks: pending-run count saturates if the head is under 600 ticks away
  task automatic tick_flood();
    sched_in_t it;
    int        n;
    n_flood++;
    it = '0;
    if (tbl_used < MAX_TASKS) begin
      it.mode = MODE_ADD;
      it.tag  = TAG_W'($urandom);
      send_item(it, 1'b0, '0);
    end
    n = 270 + ((tbl_used != 0 && tbl_delta[0] < 600) ? int'(tbl_delta[0]) : 0);
    it.mode = MODE_TICK;
    repeat (n) send_item(it, 1'b0, '0);
    it.mode = MODE_DISPATCH;
    send_item(it, 1'b0, '0);
  endtask

  // receiver: stall style changes at random intervals
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_style <= $urandom_range(0, 3);
      rx_left  <= $urandom_range(5, 60);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_style)
      0:       m_tready <= 1'b1;
      1:       m_tready <= 1'($urandom_range(0, 1));
      2:       m_tready <= ($urandom_range(0, 3) == 0);
      default: m_tready <= (rx_left % 5 != 0);
    endcase
  end

  // result checker
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      beats_seen++;
      if (sched_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected result beat status=%0d run_tag=0x%02h",
                   $time, m_tuser, m_tdata);
      end else begin
        head_exp = sched_q.pop_front();
        if (m_tuser !== head_exp.status || m_tdata !== head_exp.run_tag) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result mismatch: status exp %0d got %0d, run_tag exp 0x%02h got 0x%02h",
                     $time, head_exp.status, m_tuser, head_exp.run_tag, m_tdata);
        end
      end
    end
  end

  // stimulus
  initial begin
    int pick;
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = MODE_TICK;
    m_tready = 1'b0;

    // directed beats: empty table, one-shot and periodic tasks, field extremes
    dir_rows.push_back(mk_row(MODE_TICK,     16'd0,     16'd0,     8'h00, 1, STATUS_NONE,  8'h00));
    dir_rows.push_back(mk_row(MODE_DISPATCH, 16'd0,     16'd0,     8'h00, 1, STATUS_NONE,  8'h00));
    dir_rows.push_back(mk_row(MODE_UNUSED,   16'd0,     16'd0,     8'h00, 1, STATUS_NONE,  8'h00));
    dir_rows.push_back(mk_row(MODE_ADD,      16'd0,     16'd0,     8'hFF, 1, STATUS_ADDED, 8'h00));
    dir_rows.push_back(mk_row(MODE_DISPATCH, 16'd0,     16'd0,     8'h00, 1, STATUS_NONE,  8'h00));
    dir_rows.push_back(mk_row(MODE_TICK,     16'd0,     16'd0,     8'h00, 1, STATUS_NONE,  8'h00));
    dir_rows.push_back(mk_row(MODE_TICK,     16'd0,     16'd0,     8'h00, 1, STATUS_NONE,  8'h00));
    // two pending runs, one dispatch: the extra run is dropped
    dir_rows.push_back(mk_row(MODE_DISPATCH, 16'd0,     16'd0,     8'h00, 1, STATUS_RUN,   8'hFF));
    dir_rows.push_back(mk_row(MODE_DISPATCH, 16'd0,     16'd0,     8'h00, 1, STATUS_NONE,  8'h00));
    dir_rows.push_back(mk_row(MODE_ADD,      16'hFFFF,  16'hFFFF,  8'h00, 1, STATUS_ADDED, 8'h00));
    dir_rows.push_back(mk_row(MODE_ADD,      16'd9,     16'd10,    8'h5A, 1, STATUS_ADDED, 8'h00));
    dir_rows.push_back(mk_row(MODE_ADD,      16'd19,    16'd0,     8'hA5, 0, STATUS_NONE,  8'h00));
    dir_rows.push_back(mk_row(MODE_ADD,      16'd0,     16'd0,     8'h01, 0, STATUS_NONE,  8'h00));
    dir_rows.push_back(mk_row(MODE_TICK,     16'd0,     16'd0,     8'h00, 0, STATUS_NONE,  8'h00));
    dir_rows.push_back(mk_row(MODE_DISPATCH, 16'd0,     16'd0,     8'h00, 0, STATUS_NONE,  8'h00));
    dir_rows.push_back(mk_row(MODE_TICK,     16'd0,     16'd0,     8'h00, 0, STATUS_NONE,  8'h00));
    dir_rows.push_back(mk_row(MODE_DISPATCH, 16'd0,     16'd0,     8'h00, 0, STATUS_NONE,  8'h00));
    dir_rows.push_back(mk_row(MODE_TICK,     16'd0,     16'd0,     8'h00, 0, STATUS_NONE,  8'h00));
    dir_rows.push_back(mk_row(MODE_DISPATCH, 16'd0,     16'd0,     8'h00, 0, STATUS_NONE,  8'h00));
    dir_rows.push_back(mk_row(MODE_ADD,      16'hAAAA,  16'h5555,  8'h3C, 0, STATUS_NONE,  8'h00));
    dir_rows.push_back(mk_row(MODE_ADD,      16'h5555,  16'hAAAA,  8'hC3, 0, STATUS_NONE,  8'h00));
    dir_rows.push_back(mk_row(MODE_UNUSED,   16'hFFFF,  16'hFFFF,  8'hFF, 1, STATUS_NONE,  8'h00));
    dir_rows.push_back(mk_row(MODE_TICK,     16'd0,     16'd0,     8'h00, 0, STATUS_NONE,  8'h00));
    dir_rows.push_back(mk_row(MODE_DISPATCH, 16'd0,     16'd0,     8'h00, 0, STATUS_NONE,  8'h00));

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) send_item(dir_rows[i].stim, dir_rows[i].pinned, dir_rows[i].pinned_res);

    // quiet the sender once, then saturate the pending count at least once
    wait_drain();
    tick_flood();

    // random phases
    while (items_fed < FEED_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        repeat ($urandom_range(20, 80)) send_item(rand_mixed(), 1'b0, '0);
      end else if (pick < 70) begin
        repeat (MAX_TASKS + 2) send_item(rand_add(), 1'b0, '0);
      end else if (pick < 80) begin
        repeat ($urandom_range(10, 30)) send_item(sched_in_t'({$urandom, $urandom}), 1'b0, '0);
      end else if (pick < 88 && n_flood < 3) begin
        tick_flood();
      end else begin
        wait_drain();
      end
    end

    wait_drain();
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Fed %0d ticks, %0d adds (%0d refused, table full), %0d polls (%0d dispatched)",
             n_tick, n_add, n_full, n_poll, n_run);
    $display("%0d result beats checked; %0d ticks at the pending-run ceiling; %0d mismatches",
             beats_seen, n_sat, mismatches);
    if (mismatches == 0 && sched_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== delta_list_task_scheduler.f =====
+incdir+hw/rtl
hw/rtl/dlts_pkg.sv
hw/rtl/dlts_cell.sv
hw/rtl/delta_list_task_scheduler.sv
sim/tb_top.sv
